FILE: rtl/rope_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_pkg
// shared types, constants and fp32 helpers for the rotary pair unit
// ----------------------------------------------------------------------------
package rope_pkg;

  localparam int unsigned QueryHeads = 8;
  localparam logic [23:0] PosLimit = 24'd8388607;
  localparam logic [15:0] Bf16QNan = 16'h7FC0;
  localparam logic [31:0] F32QNan  = 32'h7FC00000;

  localparam logic CfgPositionBase = 1'b0;
  localparam logic CfgRowCount     = 1'b1;

  // routing side information carried alongside the arithmetic
  typedef struct packed {
    logic        to_key;
    logic [14:0] dest_offset;
    logic [22:0] table_row;
    logic        bad_item;
  } rope_side_t;

  // unpacked product before rounding: exact 48-bit mantissa product
  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic signed [10:0] exp;  // unbiased exponent of bit 47
    logic [47:0] mant;
  } rope_prod_t;

  function automatic logic [31:0] fp16_to_fp32(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [31:0] r;
    logic [7:0]  e32;
    logic [9:0]  mm;
    int          lz;
    e = h[14:10];
    m = h[9:0];
    r = {h[15], 31'd0};
    lz = 0;
    for (int i = 9; i >= 0; i--) begin
      if (m[i] && lz == 0) lz = 10 - i;
    end
    if (e == 5'd0) begin
      if (m != 10'd0) begin
        mm = 10'(m << lz);
        e32 = 8'(113 - lz);
        r = {h[15], e32, mm, 13'd0};
      end
    end else if (e == 5'd31) begin
      r = {h[15], 8'hFF, m, 13'd0};
      if (m != 10'd0) r[22] = 1'b1;
    end else begin
      r = {h[15], 8'(e + 8'd112), m, 13'd0};
    end
    return r;
  endfunction

  // round a positive magnitude given as 27-bit mantissa (bit 26 lead, bit 0 sticky)
  // with unbiased exponent; handles subnormal, overflow
  function automatic logic [31:0] f32_round(input logic sign, input logic signed [10:0] exp,
                                            input logic [26:0] mant);
    logic [26:0] sh;
    logic signed [11:0] be;
    logic [4:0]  shamt;
    logic        st;
    logic [24:0] rnd;
    logic [31:0] r;
    be = 12'(exp) + 12'sd127;
    sh = mant;
    if (be <= 0) begin
      shamt = (be < -12'sd26) ? 5'd27 : 5'(1 - be);
      st = 1'b0;
      for (int i = 0; i < 27; i++) begin
        if (i < int'(shamt) && mant[i]) st = 1'b1;
      end
      sh = (shamt >= 5'd27) ? 27'd0 : (mant >> shamt);
      sh[0] = sh[0] | st;
      be = 12'sd0;
    end
    rnd = {1'b0, sh[26:3]};
    if (sh[2] && (sh[1] || sh[0] || sh[3])) rnd = rnd + 25'd1;
    if (rnd[24]) begin
      be = be + 12'sd1;
      rnd = rnd >> 1;
    end else if (be == 12'sd0 && rnd[23]) begin
      be = 12'sd1;
    end
    if (be >= 12'sd255) r = {sign, 8'hFF, 23'd0};
    else r = {sign, be[7:0], rnd[22:0]};
    return r;
  endfunction

  function automatic logic [15:0] f32_to_bf16(input logic [31:0] b);
    logic [31:0] s;
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) return Bf16QNan;
    s = b + 32'h7FFF + {31'd0, b[16]};
    return s[31:16];
  endfunction

endpackage

FILE: rtl/rotary_embedding_pair_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_embedding_pair_unit
// rotate-half rope pair: fp16 widen, fp32 mul, fp32 add, bf16 round, routing
// ----------------------------------------------------------------------------
// pipeline: registers from input request to output request are widen, two multiply
//   stages, two add stages, and bf16 round into the output register
// throughput: one pair per cycle; the pipeline stalls as a whole when the
//   output register is full and not taken
// reset: valid bits cleared; position_base 0, row_count 1; data registers are not reset
module rotary_embedding_pair_unit #(
  parameter int unsigned HEAD_DIM = 256,
  parameter int unsigned MAX_ROWS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [22:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // row[3:0], head[7:4], pair_index[14:8], x_first[30:15], x_second[46:31],
  // cos_first[78:47], cos_second[110:79], sin_first[142:111],
  // sin_second[174:143], zero fill
  input  logic [175:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // y_first[15:0], y_second[31:16], to_key[32], dest_offset[47:33],
  // table_row[70:48], bad_item[71]
  output logic [71:0]  out_tdata
);
  import rope_pkg::*;

  localparam int unsigned Stages = 6;

  logic [22:0] position_base_r;
  logic [4:0]  row_count_r;

  // stage valid bits; whole pipe advances together
  logic [Stages-1:0] vld_r, vld_nxt;
  logic              adv;
  rope_side_t        side_r [Stages];

  assign adv = !vld_r[Stages-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_base_r <= '0;
      row_count_r     <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgPositionBase: position_base_r <= cfg_data;
        CfgRowCount:     row_count_r     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // unpack request
  logic [3:0]  in_row, in_head;
  logic [6:0]  in_pair;
  logic [15:0] in_xf, in_xs;
  logic [31:0] in_cf, in_cs, in_sf, in_ss;
  assign in_row  = in_tdata[3:0];
  assign in_head = in_tdata[7:4];
  assign in_pair = in_tdata[14:8];
  assign in_xf   = in_tdata[30:15];
  assign in_xs   = in_tdata[46:31];
  assign in_cf   = in_tdata[78:47];
  assign in_cs   = in_tdata[110:79];
  assign in_sf   = in_tdata[142:111];
  assign in_ss   = in_tdata[174:143];

  // side information computed at entry
  rope_side_t side_nxt;
  always_comb begin
    logic [31:0] off;
    logic [23:0] lim;
    if (32'(in_head) < QueryHeads) begin
      side_nxt.to_key = 1'b0;
      off = 32'(in_row) * 32'(QueryHeads * HEAD_DIM) + 32'(in_head) * 32'(HEAD_DIM)
          + 32'(in_pair);
    end else begin
      side_nxt.to_key = 1'b1;
      off = 32'(in_row) * 32'(HEAD_DIM) + 32'(in_pair);
    end
    side_nxt.dest_offset = off[14:0];
    side_nxt.table_row = position_base_r + 23'(in_row);
    lim = {1'b0, position_base_r} + 24'(row_count_r);
    side_nxt.bad_item = (32'(in_head) > QueryHeads) || (row_count_r == 5'd0)
                     || (32'(row_count_r) > MAX_ROWS) || ({1'b0, in_row} >= row_count_r)
                     || (lim > PosLimit);
  end

  // stage 0: widen activations
  logic [31:0] x1_r, x2_r, cf_r, cs_r, sf_r, ss_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r <= fp16_to_fp32(in_xf);
      x2_r <= fp16_to_fp32(in_xs);
      cf_r <= in_cf;
      cs_r <= in_cs;
      sf_r <= in_sf;
      ss_r <= in_ss;
    end
  end

  // stages 1-2: four multipliers
  logic [31:0] p1, q1, p2, q2;
  rope_fmul u_mul_p1 (.clk(clk), .en(adv), .a(x1_r), .b(cf_r), .p(p1));
  rope_fmul u_mul_q1 (.clk(clk), .en(adv), .a(x2_r), .b(sf_r), .p(q1));
  rope_fmul u_mul_p2 (.clk(clk), .en(adv), .a(x2_r), .b(cs_r), .p(p2));
  rope_fmul u_mul_q2 (.clk(clk), .en(adv), .a(x1_r), .b(ss_r), .p(q2));

  // stages 3-4: adders, first one subtracts
  logic [31:0] y1, y2;
  rope_fadd u_add_1 (.clk(clk), .en(adv), .a(p1), .b({~q1[31], q1[30:0]}), .s(y1));
  rope_fadd u_add_2 (.clk(clk), .en(adv), .a(p2), .b(q2), .s(y2));

  // stage 5: bf16 round into the output register
  logic [15:0] yf_r, ys_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      yf_r <= f32_to_bf16(y1);
      ys_r <= f32_to_bf16(y2);
    end
  end

  always_comb begin
    vld_nxt = {vld_r[Stages-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < Stages; i++) side_r[i] <= side_r[i-1];
    end
  end

  assign out_tvalid = vld_r[Stages-1];
  assign out_tdata = {side_r[Stages-1].bad_item, side_r[Stages-1].table_row,
                      side_r[Stages-1].dest_offset, side_r[Stages-1].to_key, ys_r, yf_r};

`ifndef SYNTHESIS
  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  // an accepted request is registered into the first stage valid bit
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted request lost at entry");
  // ready only drops while a result waits
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without back-pressure");
`endif
endmodule

FILE: rtl/rope_fmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_fmul
// fp32 multiplier, two register stages: mantissa product then normalise/round
// ----------------------------------------------------------------------------
module rope_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);
  import rope_pkg::*;

  rope_prod_t  prod_r, prod_nxt;
  logic [31:0] p_r, p_nxt;

  always_comb begin
    logic [23:0] ma, mb;
    logic signed [10:0] ea, eb;
    logic an, bn, ai, bi, az, bz;
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    ea = (a[30:23] == 8'd0) ? -11'sd126 : 11'($signed({3'd0, a[30:23]})) - 11'sd127;
    eb = (b[30:23] == 8'd0) ? -11'sd126 : 11'($signed({3'd0, b[30:23]})) - 11'sd127;
    an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    az = (a[30:0] == 31'd0);
    bz = (b[30:0] == 31'd0);
    prod_nxt.sign    = a[31] ^ b[31];
    prod_nxt.is_nan  = an || bn || (ai && bz) || (bi && az);
    prod_nxt.is_inf  = ai || bi;
    prod_nxt.is_zero = az || bz;
    prod_nxt.exp     = ea + eb + 11'sd1;
    prod_nxt.mant    = ma * mb;
  end

  always_ff @(posedge clk) begin
    if (en) prod_r <= prod_nxt;
  end

  // normalise: lead bit search over the 48-bit product
  always_comb begin
    int lz;
    logic [47:0] n;
    logic [26:0] m27;
    logic signed [10:0] e;
    lz = 47;
    for (int i = 0; i < 48; i++) begin
      if (prod_r.mant[i]) lz = 47 - i;
    end
    n = prod_r.mant << lz;
    e = prod_r.exp - 11'(lz);
    m27 = {n[47:22], (n[21:0] != 22'd0)};
    if (prod_r.is_nan) p_nxt = F32QNan;
    else if (prod_r.is_inf) p_nxt = {prod_r.sign, 8'hFF, 23'd0};
    else if (prod_r.is_zero) p_nxt = {prod_r.sign, 31'd0};
    else p_nxt = f32_round(prod_r.sign, e, m27);
  end

  always_ff @(posedge clk) begin
    if (en) p_r <= p_nxt;
  end

  assign p = p_r;
endmodule

FILE: rtl/rope_fadd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_fadd
// fp32 adder, two register stages: align and add, then normalise and round
// ----------------------------------------------------------------------------
module rope_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);
  import rope_pkg::*;

  typedef struct packed {
    logic        sign;
    logic        special;
    logic [31:0] special_val;
    logic signed [10:0] exp;
    logic [27:0] mant;  // bit 27 carry, bit 0 sticky
  } sum_t;

  sum_t        sum_r, sum_nxt;
  logic [31:0] s_r, s_nxt;

  always_comb begin
    logic [31:0] big, lit;
    logic [26:0] mb, ml, mls;
    logic [7:0]  eb, el, d;
    logic        st, an, bn, ai, bi;
    an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (a[30:0] >= b[30:0]) begin
      big = a; lit = b;
    end else begin
      big = b; lit = a;
    end
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    el = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
    mb = {(big[30:23] != 8'd0), big[22:0], 3'd0};
    ml = {(lit[30:23] != 8'd0), lit[22:0], 3'd0};
    d = eb - el;
    st = 1'b0;
    for (int i = 0; i < 27; i++) begin
      if (i < int'(d) && ml[i]) st = 1'b1;
    end
    mls = (d >= 8'd27) ? 27'd0 : (ml >> d);
    mls[0] = mls[0] | st;
    sum_nxt.sign = big[31];
    sum_nxt.exp = 11'($signed({3'd0, eb})) - 11'sd127;
    if (big[31] == lit[31]) sum_nxt.mant = {1'b0, mb} + {1'b0, mls};
    else sum_nxt.mant = {1'b0, mb} - {1'b0, mls};
    sum_nxt.special = an || bn || ai || bi;
    if (an || bn || (ai && bi && (a[31] != b[31]))) sum_nxt.special_val = F32QNan;
    else if (ai) sum_nxt.special_val = a;
    else sum_nxt.special_val = b;
    // exact zero: sign is and of both signs under nearest rounding
    if (sum_nxt.mant == 28'd0) sum_nxt.sign = a[31] & b[31];
  end

  always_ff @(posedge clk) begin
    if (en) sum_r <= sum_nxt;
  end

  always_comb begin
    int lz;
    logic [27:0] n;
    logic [26:0] m27;
    logic signed [10:0] e;
    lz = 27;
    for (int i = 0; i < 28; i++) begin
      if (sum_r.mant[i]) lz = 27 - i;
    end
    // keep subnormal range: stop the shift at the subnormal exponent
    if (11'(lz) > sum_r.exp + 11'sd128) lz = int'(sum_r.exp) + 128;
    n = sum_r.mant << lz;
    e = sum_r.exp + 11'sd1 - 11'(lz);
    m27 = {n[27:2], (n[1:0] != 2'd0)};
    if (sum_r.special) s_nxt = sum_r.special_val;
    else if (sum_r.mant == 28'd0) s_nxt = {sum_r.sign, 31'd0};
    else s_nxt = f32_round(sum_r.sign, e, m27);
  end

  always_ff @(posedge clk) begin
    if (en) s_r <= s_nxt;
  end

  assign s = s_r;
endmodule

FILE: verif/rotary_embedding_pair_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_embedding_pair_unit_tb
// self-checking bench for the rope pair unit: directed corner pairs, register
// extremes, then random pairs under changing settings and idling patterns; an
// fp32/bf16 rotation model with routing and range flags predicts each result
// ----------------------------------------------------------------------------
module rotary_embedding_pair_unit_tb;
  import rope_pkg::*;

  localparam int HeadDim = 256;
  localparam int MaxRows = 16;
  localparam int WatchdogLimit = 20000;
  localparam logic [31:0] F32One = 32'h3F800000;
  localparam logic [31:0] F32Max = 32'h7F7FFFFF;
  localparam logic [15:0] F16Max = 16'h7BFF;
  localparam logic [15:0] F16Inf = 16'h7C00;
  localparam logic [15:0] F16NaN = 16'h7E01;
  localparam logic [22:0] TopBase = 23'd8388606;

  // one rotary pair request
  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  head;
    logic [6:0]  pair_index;
    logic [15:0] x_first;
    logic [15:0] x_second;
    logic [31:0] cos_first;
    logic [31:0] cos_second;
    logic [31:0] sin_first;
    logic [31:0] sin_second;
  } pair_req_t;

  // one rotated pair with its routing, highest field first as on out_tdata
  typedef struct packed {
    logic        bad_item;
    logic [22:0] table_row;
    logic [14:0] dest_offset;
    logic        to_key;
    logic [15:0] y_second;
    logic [15:0] y_first;
  } pair_res_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic         cfg_index;
  logic [22:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [175:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;

  rotary_embedding_pair_unit #(.HEAD_DIM(HeadDim), .MAX_ROWS(MaxRows)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // model copy of the two registers
  logic [22:0] position_base;
  logic [4:0]  row_count;

  pair_res_t pending_results[$];
  int        fail_count;
  int        tx_idle_pct;
  int        rx_idle_pct;
  bit        rx_hold_go;
  int        rx_hold_left;
  int        quiet_cycles;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------------
  // arithmetic model
  // ---------------------------------------------------------------------------

  // exact widening of fp16 to fp32 bits
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [4:0] e;
    logic [10:0] m;
    logic [7:0] e32;
    e = h[14:10];
    m = {1'b0, h[9:0]};
    if (e == 5'd0) begin
      if (m == 11'd0) return {h[15], 31'd0};
      e32 = 8'd113;
      for (int i = 0; i < 11; i++) begin
        if (!m[10]) begin
          m = m << 1;
          e32 = e32 - 8'd1;
        end
      end
      return {h[15], e32, m[9:0], 13'd0};
    end
    if (e == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0} | (h[9:0] != 0 ? 32'h400000 : 32'd0);
    return {h[15], 8'(e) + 8'd112, h[9:0], 13'd0};
  endfunction

  // fp32 bits to a double, exact
  function automatic real f32_as_real(input logic [31:0] f);
    logic [7:0] e;
    logic [23:0] m;
    logic [10:0] de;
    e = f[30:23];
    m = {1'b0, f[22:0]};
    if (e == 8'hFF) return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
    if (e == 8'd0) begin
      if (m == 24'd0) return $bitstoreal({f[31], 63'd0});
      de = 11'd897;
      for (int i = 0; i < 24; i++) begin
        if (!m[23]) begin
          m = m << 1;
          de = de - 11'd1;
        end
      end
      return $bitstoreal({f[31], de, m[22:0], 29'd0});
    end
    return $bitstoreal({f[31], 11'(e) + 11'd896, f[22:0], 29'd0});
  endfunction

  // one nearest-even rounding of a double to fp32, subnormals kept
  function automatic logic [31:0] round_to_f32(input real r);
    logic [63:0] d;
    logic [63:0] mant;
    logic [63:0] kept;
    logic        s;
    logic        rb;
    logic        st;
    int          be;
    int          sh;
    d = $realtobits(r);
    s = d[63];
    if (d[62:52] == 11'h7FF)
      return (d[51:0] != 0) ? {s, 8'hFF, 23'h400000} : {s, 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {s, 31'd0};
    mant = {11'd0, 1'b1, d[51:0]};
    be = int'(d[62:52]) - 1023 + 127;
    sh = (be >= 1) ? 29 : 30 - be;
    if (sh > 53) return {s, 31'd0};
    kept = mant >> sh;
    rb = mant[sh-1];
    st = (mant & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
    if (rb && (st || kept[0])) kept = kept + 64'd1;
    if (be >= 1) begin
      if (kept[24]) begin
        be = be + 1;
        kept = kept >> 1;
      end
      if (be >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(be), kept[22:0]};
    end
    // carry into bit 23 lands on the smallest normal
    return {s, kept[30:0]};
  endfunction

  function automatic logic [15:0] narrow_bf16(input logic [31:0] b);
    logic [31:0] t;
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) return 16'h7FC0;
    t = b + 32'h7FFF + {31'd0, b[16]};
    return t[31:16];
  endfunction

  function automatic real mul_f32(input real a, input real b);
    return f32_as_real(round_to_f32(a * b));
  endfunction

  // rotation, routing and range flags for one pair
  function automatic pair_res_t rotate_pair(input pair_req_t q);
    pair_res_t r;
    real x1, x2, p, n;
    logic [23:0] pos_end;
    x1 = f32_as_real(widen_half(q.x_first));
    x2 = f32_as_real(widen_half(q.x_second));
    p = mul_f32(x1, f32_as_real(q.cos_first));
    n = mul_f32(x2, f32_as_real(q.sin_first));
    r.y_first = narrow_bf16(round_to_f32(p + (-n)));
    p = mul_f32(x2, f32_as_real(q.cos_second));
    n = mul_f32(x1, f32_as_real(q.sin_second));
    r.y_second = narrow_bf16(round_to_f32(p + n));
    if (q.head < 4'(QueryHeads)) begin
      r.to_key = 1'b0;
      r.dest_offset = 15'(32'(q.row) * QueryHeads * HeadDim + 32'(q.head) * HeadDim
                          + 32'(q.pair_index));
    end else begin
      r.to_key = 1'b1;
      r.dest_offset = 15'(32'(q.row) * HeadDim + 32'(q.pair_index));
    end
    r.table_row = position_base + 23'(q.row);
    pos_end = 24'(position_base) + 24'(row_count);
    r.bad_item = (q.head > 4'(QueryHeads)) || row_count == 5'd0 || row_count > 5'(MaxRows)
                 || 5'(q.row) >= row_count || pos_end > PosLimit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: check, then decide readiness for the next edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pair_res_t got;
    pair_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: %h", out_tdata);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.y_first !== want.y_first) begin
            $error("y_first expected %h got %h", want.y_first, got.y_first); fail_count++;
          end
          if (got.y_second !== want.y_second) begin
            $error("y_second expected %h got %h", want.y_second, got.y_second); fail_count++;
          end
          if (got.to_key !== want.to_key) begin
            $error("to_key expected %0d got %0d", want.to_key, got.to_key); fail_count++;
          end
          if (got.dest_offset !== want.dest_offset) begin
            $error("dest_offset expected %0d got %0d", want.dest_offset, got.dest_offset);
            fail_count++;
          end
          if (got.table_row !== want.table_row) begin
            $error("table_row expected %0d got %0d", want.table_row, got.table_row);
            fail_count++;
          end
          if (got.bad_item !== want.bad_item) begin
            $error("bad_item expected %0d got %0d", want.bad_item, got.bad_item); fail_count++;
          end
        end
      end
      // long hold-off is counted here so the block backs up into its input
      if (rx_hold_go) begin
        rx_hold_go = 1'b0;
        rx_hold_left = 400;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog on cycles where neither side moves a request
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one request; valid stays high into the next call when no gap is taken
  task automatic send_pair(input pair_req_t q);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(4, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, q.sin_second, q.sin_first, q.cos_second, q.cos_first,
                 q.x_second, q.x_first, q.pair_index, q.head, q.row};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(rotate_pair(q));
  endtask

  task automatic drain_pipe;
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    // pipeline is six deep; let it settle fully
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [22:0] value);
    drain_pipe();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgPositionBase) position_base = value;
    else row_count = value[4:0];
  endtask

  task automatic send_fields(input logic [3:0] row, input logic [3:0] head,
                             input logic [6:0] pi, input logic [15:0] x1,
                             input logic [15:0] x2, input logic [31:0] c1,
                             input logic [31:0] c2, input logic [31:0] s1,
                             input logic [31:0] s2);
    send_pair('{row, head, pi, x1, x2, c1, c2, s1, s2});
  endtask

  // fp16 mostly ordinary, now and then a special pattern
  function automatic logic [15:0] rand_half();
    case ($urandom_range(9))
      0: return {1'($urandom), 5'd0, 10'($urandom)};
      1: return {1'($urandom), 5'd31, ($urandom_range(3) == 0) ? 10'd0 : 10'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  // trig words mostly of magnitude below 2, sometimes raw bit patterns
  function automatic logic [31:0] rand_trig();
    if ($urandom_range(9) == 0) return $urandom;
    return {1'($urandom), 8'($urandom_range(127, 100)), 23'($urandom)};
  endfunction

  function automatic pair_req_t rand_pair();
    pair_req_t q;
    q.row = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(row_count > 0
             ? ((row_count > 16) ? 15 : row_count - 1) : 0));
    q.head = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8));
    q.pair_index = 7'($urandom);
    q.x_first = rand_half();
    q.x_second = rand_half();
    q.cos_first = rand_trig();
    q.cos_second = rand_trig();
    q.sin_first = rand_trig();
    q.sin_second = rand_trig();
    return q;
  endfunction

  task automatic random_settings();
    case ($urandom_range(9))
      0: write_reg(CfgRowCount, 23'($urandom_range(31, 17)));
      1: write_reg(CfgRowCount, 23'd0);
      default: write_reg(CfgRowCount, 23'($urandom_range(16, 1)));
    endcase
    case ($urandom_range(4))
      0: write_reg(CfgPositionBase, 23'd0);
      1: write_reg(CfgPositionBase, TopBase - 23'($urandom_range(20)));
      default: write_reg(CfgPositionBase, 23'($urandom_range(8388606)));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // arithmetic corners and routing extremes
  task automatic test_directed_corners();
    write_reg(CfgRowCount, 23'd16);
    write_reg(CfgPositionBase, 23'd100);
    send_fields(0, 0, 0, 16'h0000, 16'h8000, F32One, F32One, F32One, F32One);
    send_fields(15, 7, 127, F16Max, F16Max, F32Max, F32Max, F32One, F32One); // overflow
    send_fields(3, 8, 127, F16Inf, F16Inf, F32One, F32One, F32One, F32One);  // inf - inf
    send_fields(1, 8, 5, F16NaN, 16'h3C00, F32One, F32One, F32One, F32One);  // nan in
    send_fields(2, 2, 9, 16'h0001, 16'h8001, 32'h00000001, 32'h00800000,
                32'h80000001, 32'h007FFFFF);                                 // subnormals
    send_fields(4, 9, 1, 16'h3C00, 16'hBC00, 32'h3F3504F3, 32'hBF3504F3,
                32'h3F3504F3, 32'h3F3504F3);                                 // head above eight
    send_fields(15, 15, 127, 16'hFFFF, 16'hFBFF, 32'hFFFFFFFF, 32'hFF800000,
                32'h7F800000, 32'h00000000);
    send_fields(5, 4, 64, 16'h3C01, 16'h0000, 32'h3F800001, 32'h0, 32'h0, 32'h0);
    write_reg(CfgRowCount, 23'd1);
    send_fields(0, 8, 0, 16'h3555, 16'h3555, F32One, F32One, F32One, F32One);
    send_fields(1, 0, 0, 16'h3555, 16'h3555, F32One, F32One, F32One, F32One); // row out
  endtask

  // register extremes: bad row counts and the position limit
  task automatic test_register_extremes();
    write_reg(CfgRowCount, 23'd0);
    send_fields(0, 0, 1, 16'h3C00, 16'h3C00, F32One, F32One, F32One, F32One);
    write_reg(CfgRowCount, 23'd31);
    send_fields(15, 1, 2, 16'h3C00, 16'h3C00, F32One, F32One, F32One, F32One);
    write_reg(CfgRowCount, 23'd17);
    send_fields(0, 1, 2, 16'h3C00, 16'h3C00, F32One, F32One, F32One, F32One);
    write_reg(CfgRowCount, 23'd1);
    write_reg(CfgPositionBase, TopBase);
    send_fields(0, 3, 3, 16'h4000, 16'h4000, F32One, F32One, F32One, F32One);
    write_reg(CfgRowCount, 23'd2);
    send_fields(1, 3, 3, 16'h4000, 16'h4000, F32One, F32One, F32One, F32One); // past the position limit
    write_reg(CfgPositionBase, 23'd8388591);
    write_reg(CfgRowCount, 23'd16);
    send_fields(15, 8, 127, 16'h4000, 16'h4000, F32One, F32One, F32One, F32One);
    write_reg(CfgPositionBase, 23'd8388592);
    send_fields(15, 8, 127, 16'h4000, 16'h4000, F32One, F32One, F32One, F32One);
    write_reg(CfgPositionBase, 23'd0);
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int chunks);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int c = 0; c < chunks; c++) begin
      random_settings();
      for (int i = 0; i < 130; i++) send_pair(rand_pair());
    end
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CfgRowCount, 23'd16);
    rx_hold_go = 1'b1;
    for (int i = 0; i < 60; i++) send_pair(rand_pair());
    // sender waits until every result is back
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    for (int i = 0; i < 30; i++) send_pair(rand_pair());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgPositionBase;
    cfg_data = 23'd0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    position_base = 23'd0;
    row_count = 5'd1;
    fail_count = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_go = 1'b0;
    rx_hold_left = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_register_extremes();
    test_random_phase(37, 49, 5);
    test_random_phase(49, 37, 5);
    test_backpressure();
    test_random_phase(0, 0, 4);

    drain_pipe();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
